### sv/bga_pkg.sv
// Shared types and constants for the brick grid address unit.
`timescale 1ns / 1ps
`default_nettype none

package bga_pkg;

    // Request selector carried on tuser.
    typedef enum logic [2:0] {
        REQ_VOXEL = 3'd0,
        REQ_XM    = 3'd1,
        REQ_XP    = 3'd2,
        REQ_YM    = 3'd3,
        REQ_YP    = 3'd4,
        REQ_ZM    = 3'd5,
        REQ_ZP    = 3'd6,
        REQ_NONE  = 3'd7
    } bga_req_t;

    // Configuration register indexes.
    localparam logic [2:0] CFG_BRICKS_X    = 3'd0;
    localparam logic [2:0] CFG_BRICKS_Y    = 3'd1;
    localparam logic [2:0] CFG_BRICKS_Z    = 3'd2;
    localparam logic [2:0] CFG_VOL_WIDTH   = 3'd3;
    localparam logic [2:0] CFG_VOL_HEIGHT  = 3'd4;
    localparam logic [2:0] CFG_BRICK_SZ_X  = 3'd5;
    localparam logic [2:0] CFG_BRICK_SZ_Y  = 3'd6;
    localparam logic [2:0] CFG_BRICK_SZ_Z  = 3'd7;

    localparam int RES_W = 31;  // {out_of_range, brick_index}

    // Grid values derived from the registers.
    typedef struct packed {
        logic [10:0] bx;
        logic [10:0] by;
        logic [10:0] bz;
        logic [21:0] plane;
        logic [32:0] total;
        logic        zero_x;   // brick size x <= 1
        logic        zero_y;
        logic        zero_z;
    } bga_geom_t;

    // Sideband through the first divider.
    typedef struct packed {
        bga_req_t    req;
        logic [29:0] id;
    } bga_s1_t;

    // Sideband through the second divider.
    typedef struct packed {
        bga_req_t    req;
        logic [29:0] id;
        logic [39:0] z;
    } bga_s2_t;

    // Sideband through the third divider bank.
    typedef struct packed {
        bga_req_t    req;
        logic [29:0] id;
        logic [14:0] x;
        logic [29:0] y;
        logic [39:0] z;
    } bga_s3_t;

endpackage

`default_nettype wire

### sv/bga_div.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband.
`timescale 1ns / 1ps
`default_nettype none

module bga_div #(
    parameter int NUM_W  = 40,
    parameter int DEN_W  = 30,
    parameter int SIDE_W = 1
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [NUM_W-1:0]  in_num,
    input  wire logic [DEN_W-1:0]  in_den,
    input  wire logic [SIDE_W-1:0] in_side,
    output logic                   out_valid,
    output logic [NUM_W-1:0]       out_quo,
    output logic [DEN_W-1:0]       out_rem,
    output logic [SIDE_W-1:0]      out_side
);
    // num_reg shifts dividend bits out the top and quotient bits in the bottom
    logic              vld_reg  [NUM_W];
    logic [NUM_W-1:0]  num_reg  [NUM_W];
    logic [DEN_W-1:0]  rem_reg  [NUM_W];
    logic [DEN_W-1:0]  den_reg  [NUM_W];
    logic [SIDE_W-1:0] side_reg [NUM_W];

    for (genvar s = 0; s < NUM_W; s++) begin : g_stage
        logic              p_vld;
        logic [NUM_W-1:0]  p_num;
        logic [DEN_W-1:0]  p_rem;
        logic [DEN_W-1:0]  p_den;
        logic [SIDE_W-1:0] p_side;
        logic [DEN_W:0]    trial;
        logic              ge;
        logic [NUM_W-1:0]  num_next;
        logic [DEN_W-1:0]  rem_next;

        if (s == 0) begin : g_first
            assign p_vld  = in_valid;
            assign p_num  = in_num;
            assign p_rem  = '0;
            assign p_den  = in_den;
            assign p_side = in_side;
        end else begin : g_next
            assign p_vld  = vld_reg[s-1];
            assign p_num  = num_reg[s-1];
            assign p_rem  = rem_reg[s-1];
            assign p_den  = den_reg[s-1];
            assign p_side = side_reg[s-1];
        end

        assign trial    = {p_rem, p_num[NUM_W-1]};
        assign ge       = (trial >= {1'b0, p_den});
        assign num_next = {p_num[NUM_W-2:0], ge};
        assign rem_next = ge ? DEN_W'(trial - {1'b0, p_den}) : trial[DEN_W-1:0];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[s] <= 1'b0;
            end else if (en) begin
                vld_reg[s] <= p_vld;
            end
            if (en) begin
                num_reg[s]  <= num_next;
                rem_reg[s]  <= rem_next;
                den_reg[s]  <= p_den;
                side_reg[s] <= p_side;
            end
        end
    end

    assign out_valid = vld_reg[NUM_W-1];
    assign out_quo   = num_reg[NUM_W-1];
    assign out_rem   = rem_reg[NUM_W-1];
    assign out_side  = side_reg[NUM_W-1];

endmodule

`default_nettype wire

### sv/bga_merge.sv
// Brick id assembly, neighbor selection and range flag after the dividers.
`timescale 1ns / 1ps
`default_nettype none

module bga_merge (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                en,
    input  wire bga_pkg::bga_geom_t  geom,
    input  wire logic                in_valid,
    input  wire bga_pkg::bga_s3_t    in_side,
    input  wire logic [39:0]         in_qx,
    input  wire logic [39:0]         in_qy,
    input  wire logic [39:0]         in_qz,
    output logic                     out_valid,
    output logic [bga_pkg::RES_W-1:0] out_res
);
    import bga_pkg::*;

    // stage 1: partial products, neighbor edge test and candidate
    logic        v1_reg;
    bga_req_t    req1_reg;
    logic [29:0] id1_reg;
    logic [14:0] qx1_reg;
    logic [41:0] zp_lo_reg, zp_hi_reg;
    logic [25:0] yb_reg;
    logic        edge1_reg;
    logic [30:0] cand1_reg;

    logic [14:0] qx_eff, qy_eff;
    logic [39:0] qz_eff;
    logic        edge_next;
    logic [30:0] cand_next;

    assign qx_eff = geom.zero_x ? '0 : in_qx[14:0];
    assign qy_eff = geom.zero_y ? '0 : in_qy[14:0];
    assign qz_eff = geom.zero_z ? '0 : in_qz;

    always_comb begin
        edge_next = 1'b1;
        cand_next = {1'b0, in_side.id};
        case (in_side.req)
            REQ_XM: begin
                edge_next = (in_side.x == '0);
                cand_next = 31'(in_side.id) - 31'd1;
            end
            REQ_XP: begin
                edge_next = (16'(in_side.x) == 16'(geom.bx) - 16'd1);
                cand_next = 31'(in_side.id) + 31'd1;
            end
            REQ_YM: begin
                edge_next = (in_side.y == '0);
                cand_next = 31'(in_side.id) - 31'(geom.bx);
            end
            REQ_YP: begin
                edge_next = (31'(in_side.y) == 31'(geom.by) - 31'd1);
                cand_next = 31'(in_side.id) + 31'(geom.bx);
            end
            REQ_ZM: begin
                edge_next = (in_side.z == '0);
                cand_next = 31'(in_side.id) - 31'(geom.plane);
            end
            REQ_ZP: begin
                edge_next = (41'(in_side.z) == 41'(geom.bz) - 41'd1);
                cand_next = 31'(in_side.id) + 31'(geom.plane);
            end
            default: begin
                edge_next = 1'b1;
                cand_next = {1'b0, in_side.id};
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
        end
        if (en) begin
            req1_reg  <= in_side.req;
            id1_reg   <= in_side.id;
            qx1_reg   <= qx_eff;
            zp_lo_reg <= 42'(qz_eff[19:0]) * 42'(geom.plane);
            zp_hi_reg <= 42'(qz_eff[39:20]) * 42'(geom.plane);
            yb_reg    <= 26'(qy_eff) * 26'(geom.bx);
            edge1_reg <= edge_next;
            cand1_reg <= cand_next;
        end
    end

    // stage 2: join partial products, neighbor range check
    logic        v2_reg;
    bga_req_t    req2_reg;
    logic [61:0] zp2_reg;
    logic [26:0] yx2_reg;
    logic [29:0] nres2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
        if (en) begin
            req2_reg  <= req1_reg;
            zp2_reg   <= 62'({zp_hi_reg, 20'b0}) + 62'(zp_lo_reg);
            yx2_reg   <= 27'(yb_reg) + 27'(qx1_reg);
            nres2_reg <= (edge1_reg || (33'(cand1_reg) >= geom.total)) ?
                         id1_reg : cand1_reg[29:0];
        end
    end

    // stage 3: full brick id
    logic        v3_reg;
    bga_req_t    req3_reg;
    logic [61:0] bid3_reg;
    logic [29:0] nres3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
        if (en) begin
            req3_reg  <= req2_reg;
            bid3_reg  <= zp2_reg + 62'(yx2_reg);
            nres3_reg <= nres2_reg;
        end
    end

    logic flag;
    assign flag      = (req3_reg == REQ_VOXEL) && (bid3_reg >= 62'(geom.total));
    assign out_valid = v3_reg;
    assign out_res   = {flag, (req3_reg == REQ_VOXEL) ? bid3_reg[29:0] : nres3_reg};

endmodule

`default_nettype wire

### sv/bga_obuf.sv
// Two-entry output buffer; decouples the pipeline from the result channel.
`timescale 1ns / 1ps
`default_nettype none

module bga_obuf (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      push,
    input  wire logic [bga_pkg::RES_W-1:0] push_data,
    output logic                           has_room,
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic [bga_pkg::RES_W-1:0]      head
);
    import bga_pkg::*;

    logic [1:0]       cnt_reg;
    logic [RES_W-1:0] head_reg, tail_reg;
    logic             pop;

    assign pop      = m_tvalid && m_tready;
    assign m_tvalid = (cnt_reg != 2'd0);
    assign has_room = (cnt_reg != 2'd2);
    assign head     = head_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            case (cnt_reg)
                2'd0: if (push) cnt_reg <= 2'd1;
                2'd1: begin
                    if (push && !pop) cnt_reg <= 2'd2;
                    else if (!push && pop) cnt_reg <= 2'd0;
                end
                2'd2: if (pop) cnt_reg <= 2'd1;
                default: cnt_reg <= 2'd0;
            endcase
        end
        case (cnt_reg)
            2'd0: if (push) head_reg <= push_data;
            2'd1: begin
                if (push && pop) head_reg <= push_data;
                else if (push) tail_reg <= push_data;
            end
            2'd2: if (pop) head_reg <= tail_reg;
            default: ;
        endcase
    end

    a_cnt_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3) else $error("output buffer count corrupt");
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd2) |-> !push) else $error("push into full buffer");
    a_first_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd0 && push) |=> (m_tvalid && head_reg == $past(push_data)))
        else $error("beat lost entering empty buffer");

endmodule

`default_nettype wire

### sv/brick_grid_addressing.sv
// Top level of the brick grid address unit: config, input stage, dividers, output.
`timescale 1ns / 1ps
`default_nettype none

// Pipeline: the input register loads on the accepting edge, then 40 + 30 + 40
//   divider stages at one quotient bit each, 3 assembly stages, 1 output register.
// Throughput: one request per cycle; the pipeline halts only while both output
//   buffer entries are held by a stalled result channel.
// Reset: aresetn synchronous, active low; clears valid bits and buffer count and
//   sets all geometry registers to 1.

module brick_grid_addressing (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration write port
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [14:0] cfg_data,
    // request channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [71:0] s_tdata,   // [39:0] voxel_index, [69:40] brick_id
    input  wire logic [2:0]  s_tuser,   // [2:0] req_type
    // result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata    // [29:0] brick_index, [30] out_of_range
);
    import bga_pkg::*;

    // ---------------- configuration registers ----------------
    logic [10:0] bricks_x_reg, bricks_y_reg, bricks_z_reg;
    logic [14:0] vol_w_reg, vol_h_reg;
    logic [12:0] bsz_x_reg, bsz_y_reg, bsz_z_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bricks_x_reg <= 11'd1;
            bricks_y_reg <= 11'd1;
            bricks_z_reg <= 11'd1;
            vol_w_reg    <= 15'd1;
            vol_h_reg    <= 15'd1;
            bsz_x_reg    <= 13'd1;
            bsz_y_reg    <= 13'd1;
            bsz_z_reg    <= 13'd1;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_BRICKS_X:   bricks_x_reg <= cfg_data[10:0];
                CFG_BRICKS_Y:   bricks_y_reg <= cfg_data[10:0];
                CFG_BRICKS_Z:   bricks_z_reg <= cfg_data[10:0];
                CFG_VOL_WIDTH:  vol_w_reg    <= cfg_data;
                CFG_VOL_HEIGHT: vol_h_reg    <= cfg_data;
                CFG_BRICK_SZ_X: bsz_x_reg    <= cfg_data[12:0];
                CFG_BRICK_SZ_Y: bsz_y_reg    <= cfg_data[12:0];
                CFG_BRICK_SZ_Z: bsz_z_reg    <= cfg_data[12:0];
                default: ;
            endcase
        end
    end

    // ---------------- derived geometry ----------------
    // Recomputed every cycle; slice and plane are registered from the config registers
    // and total from plane, so a request already in flight can see old values.
    logic [14:0] nx_eff, ny_eff;
    logic [10:0] bx_nz;
    logic [29:0] slice_reg;
    logic [21:0] plane_reg;
    logic [32:0] total_reg;
    logic [12:0] bsm1_x, bsm1_y, bsm1_z;
    bga_geom_t   geom;

    assign nx_eff = (vol_w_reg == '0) ? 15'd1 : vol_w_reg;
    assign ny_eff = (vol_h_reg == '0) ? 15'd1 : vol_h_reg;
    assign bx_nz  = (bricks_x_reg == '0) ? 11'd1 : bricks_x_reg;

    // brick size minus one; sizes <= 1 divide by 1 and get zeroed after
    assign bsm1_x = (bsz_x_reg <= 13'd1) ? 13'd1 : bsz_x_reg - 13'd1;
    assign bsm1_y = (bsz_y_reg <= 13'd1) ? 13'd1 : bsz_y_reg - 13'd1;
    assign bsm1_z = (bsz_z_reg <= 13'd1) ? 13'd1 : bsz_z_reg - 13'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slice_reg <= 30'd1;
            plane_reg <= 22'd1;
            total_reg <= 33'd1;
        end else begin
            slice_reg <= 30'(nx_eff) * 30'(ny_eff);
            plane_reg <= 22'(bricks_x_reg) * 22'(bricks_y_reg);
            total_reg <= 33'(plane_reg) * 33'(bricks_z_reg);
        end
    end

    assign geom.bx     = bricks_x_reg;
    assign geom.by     = bricks_y_reg;
    assign geom.bz     = bricks_z_reg;
    assign geom.plane  = plane_reg;
    assign geom.total  = total_reg;
    assign geom.zero_x = (bsz_x_reg <= 13'd1);
    assign geom.zero_y = (bsz_y_reg <= 13'd1);
    assign geom.zero_z = (bsz_z_reg <= 13'd1);

    // ---------------- pipeline enable ----------------
    // Single enable from a registered buffer count: keeps the stall fan-out
    // off any combinational ready chain.
    logic en;
    logic has_room;
    assign en       = has_room;
    assign s_tready = en;

    // ---------------- input register ----------------
    logic        in_vld_reg;
    bga_req_t    req_reg;
    logic [39:0] vidx_reg;
    logic [29:0] id_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (en) begin
            in_vld_reg <= s_tvalid;
        end
        if (en) begin
            req_reg  <= bga_req_t'(s_tuser);
            vidx_reg <= s_tdata[39:0];
            id_reg   <= s_tdata[69:40];
        end
    end

    // ---------------- divider 1: index / slice (voxel) or id / plane ----------
    logic [21:0] plane_nz;
    logic        is_vox;
    logic [39:0] d1_num;
    logic [29:0] d1_den;
    bga_s1_t     d1_side;
    logic        d1_vld;
    logic [39:0] d1_quo;
    logic [29:0] d1_rem;
    bga_s1_t     d1_oside;

    assign plane_nz     = (plane_reg == '0) ? 22'd1 : plane_reg;
    assign is_vox       = (req_reg == REQ_VOXEL);
    assign d1_num       = is_vox ? vidx_reg : 40'(id_reg);
    assign d1_den       = is_vox ? slice_reg : 30'(plane_nz);
    assign d1_side.req  = req_reg;
    assign d1_side.id   = id_reg;

    bga_div #(.NUM_W(40), .DEN_W(30), .SIDE_W($bits(bga_s1_t))) u_div_slice (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (in_vld_reg),
        .in_num    (d1_num),
        .in_den    (d1_den),
        .in_side   (d1_side),
        .out_valid (d1_vld),
        .out_quo   (d1_quo),
        .out_rem   (d1_rem),
        .out_side  (d1_oside)
    );

    // ---------------- divider 2: remainder / row width ----------------
    logic [14:0] d2_den;
    bga_s2_t     d2_side;
    logic        d2_vld;
    logic [29:0] d2_quo;
    logic [14:0] d2_rem;
    bga_s2_t     d2_oside;

    assign d2_den      = (d1_oside.req == REQ_VOXEL) ? nx_eff : 15'(bx_nz);
    assign d2_side.req = d1_oside.req;
    assign d2_side.id  = d1_oside.id;
    assign d2_side.z   = d1_quo;

    bga_div #(.NUM_W(30), .DEN_W(15), .SIDE_W($bits(bga_s2_t))) u_div_row (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (d1_vld),
        .in_num    (d1_rem),
        .in_den    (d2_den),
        .in_side   (d2_side),
        .out_valid (d2_vld),
        .out_quo   (d2_quo),
        .out_rem   (d2_rem),
        .out_side  (d2_oside)
    );

    // ---------------- divider bank 3: coordinate / (brick size - 1) ----------
    // Three lanes of equal depth so the results line up; z carries the sideband.
    bga_s3_t     d3_side;
    logic        d3_vld;
    logic [39:0] qx, qy, qz;
    logic [12:0] rx, ry, rz;
    bga_s3_t     d3_oside;
    logic        vx_unused, vy_unused;
    logic        sx_unused, sy_unused;

    assign d3_side.req = d2_oside.req;
    assign d3_side.id  = d2_oside.id;
    assign d3_side.x   = d2_rem;
    assign d3_side.y   = d2_quo;
    assign d3_side.z   = d2_oside.z;

    bga_div #(.NUM_W(40), .DEN_W(13), .SIDE_W(1)) u_div_bx (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (d2_vld),
        .in_num    (40'(d2_rem)),
        .in_den    (bsm1_x),
        .in_side   (1'b0),
        .out_valid (vx_unused),
        .out_quo   (qx),
        .out_rem   (rx),
        .out_side  (sx_unused)
    );

    bga_div #(.NUM_W(40), .DEN_W(13), .SIDE_W(1)) u_div_by (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (d2_vld),
        .in_num    (40'(d2_quo)),
        .in_den    (bsm1_y),
        .in_side   (1'b0),
        .out_valid (vy_unused),
        .out_quo   (qy),
        .out_rem   (ry),
        .out_side  (sy_unused)
    );

    bga_div #(.NUM_W(40), .DEN_W(13), .SIDE_W($bits(bga_s3_t))) u_div_bz (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (d2_vld),
        .in_num    (d2_oside.z),
        .in_den    (bsm1_z),
        .in_side   (d3_side),
        .out_valid (d3_vld),
        .out_quo   (qz),
        .out_rem   (rz),
        .out_side  (d3_oside)
    );

    // ---------------- assembly ----------------
    logic             res_vld;
    logic [RES_W-1:0] res_data;

    bga_merge u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .geom      (geom),
        .in_valid  (d3_vld),
        .in_side   (d3_oside),
        .in_qx     (qx),
        .in_qy     (qy),
        .in_qz     (qz),
        .out_valid (res_vld),
        .out_res   (res_data)
    );

    // ---------------- output buffer ----------------
    logic [RES_W-1:0] head;

    bga_obuf u_obuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_vld && en),
        .push_data (res_data),
        .has_room  (has_room),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .head      (head)
    );

    assign m_tdata = {1'b0, head};

endmodule

`default_nettype wire

### tb/tb_brick_grid_addressing.sv
// Self-checking testbench for the brick grid address unit.
`timescale 1ns / 1ps

module tb_brick_grid_addressing;
    import bga_pkg::*;

    // Any stretch this long with no beat on either side means the block hung.
    // Worst case: the pipeline latency plus a long stall or gap, well below this.
    localparam int HANG_LIMIT = 4000;

    typedef struct {
        logic [29:0] brick_index;
        logic        out_of_range;
    } lookup_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = CFG_BRICKS_X;
    logic [14:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;      // [39:0] voxel_index, [69:40] brick_id
    logic [2:0]  s_tuser = REQ_VOXEL; // [2:0] req_type
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;           // [29:0] brick_index, [30] out_of_range

    // Predictor's copy of the geometry registers.
    logic [63:0] grid_x = 1, grid_y = 1, grid_z = 1;
    logic [63:0] vol_w = 1, vol_h = 1;
    logic [63:0] bsz_x = 1, bsz_y = 1, bsz_z = 1;

    lookup_t pending_lookups[$];
    int      mismatches = 0;
    int      idle_cycles = 0;
    bit      no_idle = 1'b0;   // burst stretches: both sides run flat out
    int      stall_left = 0;

    brick_grid_addressing u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ---------------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------------
    function automatic logic [63:0] brick_of_coord(logic [63:0] coord, logic [63:0] bsz);
        if (bsz <= 1) return 0;
        return coord / (bsz - 1);
    endfunction

    // Neighbor lookup; falls back to the id itself at the edge or past the grid.
    function automatic logic [63:0] neighbor_id(bga_req_t dir, logic [63:0] id);
        logic [63:0] plane, total, x, y, z, r;
        plane = grid_x * grid_y;
        total = plane * grid_z;
        if (total == 0) return id;
        x = (id % plane) % grid_x;
        y = (id % plane) / grid_x;
        z = id / plane;
        case (dir)
            REQ_XM: begin if (x == 0) return id; r = id - 1; end
            REQ_XP: begin if (x == grid_x - 1) return id; r = id + 1; end
            REQ_YM: begin if (y == 0) return id; r = id - grid_x; end
            REQ_YP: begin if (y == grid_y - 1) return id; r = id + grid_x; end
            REQ_ZM: begin if (z == 0) return id; r = id - plane; end
            default: begin if (z == grid_z - 1) return id; r = id + plane; end
        endcase
        return (r >= total) ? id : r;
    endfunction

    function automatic lookup_t predict_lookup(bga_req_t req, logic [39:0] vidx,
                                               logic [29:0] id);
        lookup_t res;
        logic [63:0] nx, ny, slice, x, y, z, rem, bid;
        res.out_of_range = 1'b0;
        if (req == REQ_VOXEL) begin
            nx = (vol_w != 0) ? vol_w : 1;   // zero volume size counts as 1
            ny = (vol_h != 0) ? vol_h : 1;
            slice = nx * ny;
            z = {24'd0, vidx} / slice;
            rem = {24'd0, vidx} % slice;
            x = brick_of_coord(rem % nx, bsz_x);
            y = brick_of_coord(rem / nx, bsz_y);
            z = brick_of_coord(z, bsz_z);
            bid = z * grid_x * grid_y + y * grid_x + x;
            res.brick_index = bid[29:0];
            res.out_of_range = (bid >= grid_x * grid_y * grid_z);  // full-width compare
        end else if (req == REQ_NONE) begin
            res.brick_index = id;
        end else begin
            bid = neighbor_id(req, {34'd0, id});
            res.brick_index = bid[29:0];
        end
        return res;
    endfunction

    // ---------------------------------------------------------------------
    // Result side: random backpressure and the checker
    // ---------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else begin
            int g;
            g = pick_gap();
            stall_left <= g;
            m_tready <= (g == 0);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_lookups.size() == 0) begin
                $display("%0t: result beat with nothing expected, actual %h", $time, m_tdata);
                mismatches++;
            end else begin
                lookup_t exp_res;
                exp_res = pending_lookups.pop_front();
                if (m_tdata[29:0] !== exp_res.brick_index) begin
                    $display("%0t: brick_index expected %0d actual %0d", $time,
                             exp_res.brick_index, m_tdata[29:0]);
                    mismatches++;
                end
                if (m_tdata[30] !== exp_res.out_of_range) begin
                    $display("%0t: out_of_range expected %0b actual %0b", $time,
                             exp_res.out_of_range, m_tdata[30]);
                    mismatches++;
                end
            end
        end
    end

    // Hang detector: cycles with no beat on either channel.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= HANG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------
    // One request beat. tvalid is only dropped before a real gap, so back-to-back
    // beats never see a lower and a raise of tvalid in the same step.
    task automatic send_lookup(bga_req_t req, logic [39:0] vidx, logic [29:0] id);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {2'b00, id, vidx};
        do @(posedge aclk); while (!s_tready);
        pending_lookups.insert(pending_lookups.size(), predict_lookup(req, vidx, id));
    endtask

    // Stop sending and let every outstanding result drain.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_lookups.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Register writes happen only while the pipeline is empty.
    task automatic set_geometry(int bx, int by, int bz, int vw, int vh,
                                int sx, int sy, int sz);
        logic [14:0] vals[8];
        vals = '{15'(bx), 15'(by), 15'(bz), 15'(vw), 15'(vh),
                 15'(sx), 15'(sy), 15'(sz)};
        for (int i = 0; i < 8; i++) begin
            @(posedge aclk);
            cfg_wr_en <= 1'b1;
            cfg_index <= i[2:0];
            cfg_data  <= vals[i];
        end
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        grid_x = vals[0][10:0]; grid_y = vals[1][10:0]; grid_z = vals[2][10:0];
        vol_w  = vals[3];       vol_h  = vals[4];
        bsz_x  = vals[5][12:0]; bsz_y  = vals[6][12:0]; bsz_z  = vals[7][12:0];
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------
    // Reset geometry: a single 1x1x1 brick; voxels map to brick 0, others keep the id.
    task automatic test_reset_geometry();
        send_lookup(REQ_VOXEL, '0, '0);
        send_lookup(REQ_VOXEL, '1, '1);
        send_lookup(REQ_XP, '0, '0);
        send_lookup(REQ_ZM, '1, '1);
        send_lookup(REQ_NONE, '1, 30'h2AAA_AAAA);
        drain();
    endtask

    // Field extremes, every request kind, grid edges and ids past the grid.
    task automatic test_directed_edges();
        logic [29:0] last;
        set_geometry(4, 3, 2, 10, 8, 4, 3, 5);
        last = 30'(4 * 3 * 2 - 1);
        send_lookup(REQ_VOXEL, '0, '0);
        send_lookup(REQ_VOXEL, 40'd79, '0);
        send_lookup(REQ_VOXEL, '1, '0);          // far outside: flagged
        for (int d = REQ_XM; d <= REQ_ZP; d++) begin
            send_lookup(bga_req_t'(d), '0, '0);
            send_lookup(bga_req_t'(d), '0, last);
        end
        send_lookup(REQ_XP, '0, last + 1);        // id beyond the grid
        send_lookup(REQ_ZM, '0, last + 5);
        send_lookup(REQ_YP, '0, '1);
        send_lookup(REQ_NONE, '1, 30'h1555_5555);
        drain();
    endtask

    // One geometry, n random requests, mostly well-formed for that geometry.
    task automatic test_geometry_phase(int bx, int by, int bz, int vw, int vh,
                                       int sx, int sy, int sz, int n);
        logic [63:0] total, span, v, idv;
        bga_req_t req;
        int r;
        set_geometry(bx, by, bz, vw, vh, sx, sy, sz);
        total = grid_x * grid_y * grid_z;
        span = ((vol_w != 0) ? vol_w : 1) * ((vol_h != 0) ? vol_h : 1)
               * ((grid_z != 0) ? grid_z : 1) * ((bsz_z > 1) ? bsz_z - 1 : 2);
        if (span > 64'hFF_FFFF_FFFF) span = 64'hFF_FFFF_FFFF;
        for (int i = 0; i < n; i++) begin
            no_idle = (i % 64) >= 48;
            r = $urandom_range(0, 99);
            req = (r < 35) ? REQ_VOXEL : (r < 95) ? bga_req_t'($urandom_range(1, 6))
                                                  : REQ_NONE;
            v = ($urandom_range(0, 9) < 7) ? rand64() % span : rand64();
            r = $urandom_range(0, 9);
            if (r < 7 && total != 0) idv = rand64() % total;
            else if (r < 8)          idv = total - 1;
            else if (r < 9)          idv = total;
            else                     idv = rand64();
            send_lookup(req, v[39:0], idv[29:0]);
        end
        no_idle = 1'b0;
        drain();   // also holds the sender until every result is back
    endtask

    task automatic test_random_small_grids(int phases);
        for (int p = 0; p < phases; p++)
            test_geometry_phase($urandom_range(1, 9), $urandom_range(1, 9),
                                $urandom_range(1, 9), $urandom_range(1, 40),
                                $urandom_range(1, 40), $urandom_range(0, 9),
                                $urandom_range(0, 9), $urandom_range(0, 9), 120);
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_geometry();
        test_directed_edges();
        test_geometry_phase(2, 2, 2, 8, 8, 5, 5, 5, 120);
        test_geometry_phase(7, 5, 3, 20, 13, 4, 3, 6, 120);
        // large power-of-two grid and volume
        test_geometry_phase(1024, 1024, 1024, 16384, 16384, 4096, 4096, 4096, 120);
        // every register bit set
        test_geometry_phase(2047, 2047, 2047, 32767, 32767, 8191, 8191, 8191, 120);
        // zero brick count along one axis
        test_geometry_phase(5, 0, 4, 12, 9, 3, 3, 3, 100);
        // zero volume size and brick sizes of 0 and 2
        test_geometry_phase(16, 16, 16, 0, 0, 0, 2, 2, 100);
        test_geometry_phase(300, 1, 700, 1000, 7, 2, 0, 1, 100);
        test_random_small_grids(5);
        test_geometry_phase($urandom_range(1, 2047), $urandom_range(1, 2047),
                            $urandom_range(1, 2047), $urandom_range(1, 32767),
                            $urandom_range(1, 32767), $urandom_range(0, 8191),
                            $urandom_range(0, 8191), $urandom_range(0, 8191), 120);
        test_geometry_phase(1, 1, 1, 1, 1, 1, 1, 1, 60);

        repeat (130) @(posedge aclk);   // let any stray beat surface
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
